// ===== sv/okset_pkg.sv =====
// Shared constants and types for the ordered key set.
// Holds the store geometry, the operation codes and the controller states.
`default_nettype none
package okset_pkg;
	localparam int CAPACITY  = 256;
	localparam int KEY_WIDTH = 32;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_EXIST  = 3'd2,
		OP_NEXT   = 3'd3,
		OP_PREV   = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_PCHK,
		ST_SHRD,
		ST_SHWR,
		ST_INS,
		ST_DEL,
		ST_FETCH
	} state_t;
endpackage
`default_nettype wire

// ===== sv/ordered_key_set_top.sv =====
// Ordered key set: controller with binary search and shift sequencer.
// Depends on okset_pkg and okset_ram.
//
// Usage: drive opcode and key with start high while busy is low; that
// edge accepts the transaction. Exactly one result follows, shown for one
// cycle with done high: found, result_key, rejected and occupancy (count
// of keys held after the operation). The receiver cannot stall; results
// are never held.
// Keys sit in ascending signed order in a 256-entry RAM with a registered
// read port. A lower-bound binary search spends a read state (SRD) and
// a compare state (SCMP) on each halving, then makes one probe read.
// Insert and delete then shift the tail of the store one entry at a
// time, each with a read (SHRD) and then a write (SHWR). An unused
// opcode is answered straight from idle, in the next cycle. busy stays
// high until the result is shown, so one transaction is in flight at a
// time.
// Reset empties the set at once (count cleared); no clearing pass runs.
`default_nettype none
module ordered_key_set_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic signed [31:0] key,
	output logic             done,
	output logic             found,
	output logic signed [31:0] result_key,
	output logic             rejected,
	output logic [8:0]       occupancy
);
	localparam int AW = okset_pkg::ADDR_W;
	localparam int CW = okset_pkg::CNT_W;
	localparam int KW = okset_pkg::KEY_WIDTH;

	okset_pkg::state_t state_q, state_d;
	logic [2:0]    op_q, op_d;
	logic [KW-1:0] key_q, key_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, idx_q, idx_d;
	logic [CW:0]   mid_sum;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [KW-1:0] wdata, rdata;

	logic          emit, found_d, rej_d;
	logic [KW-1:0] res_d;
	logic          hit;
	logic [CW-1:0] nxt_idx;

	okset_ram #(.DEPTH(okset_pkg::CAPACITY), .WIDTH(KW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign hit     = (lo_q < count_q) && (rdata == key_q);
	assign nxt_idx = hit ? lo_q + CW'(1) : lo_q;
	assign busy    = (state_q != okset_pkg::ST_IDLE);

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= okset_pkg::ST_IDLE;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		idx_q <= idx_d;
		if (emit) begin
			found      <= found_d;
			result_key <= res_d;
			rejected   <= rej_d;
			occupancy  <= count_d;
		end
	end

	// next state, memory access and result
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		key_d   = key_q;
		count_d = count_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		idx_d   = idx_q;
		we      = 1'b0;
		waddr   = idx_q[AW-1:0];
		wdata   = rdata;
		raddr   = lo_q[AW-1:0];
		emit    = 1'b0;
		found_d = 1'b0;
		rej_d   = 1'b0;
		res_d   = '0;
		unique case (state_q)
			okset_pkg::ST_IDLE: begin
				if (start) begin
					op_d  = opcode;
					key_d = key;
					lo_d  = '0;
					hi_d  = count_q;
					if (opcode > 3'(okset_pkg::OP_PREV)) begin
						emit = 1'b1;
					end else begin
						state_d = okset_pkg::ST_SRD;
					end
				end
			end
			okset_pkg::ST_SRD: begin
				if (lo_q == hi_q) begin
					raddr   = lo_q[AW-1:0];
					state_d = okset_pkg::ST_PCHK;
				end else begin
					mid_d   = mid_sum[CW:1];
					raddr   = mid_sum[AW:1];
					state_d = okset_pkg::ST_SCMP;
				end
			end
			okset_pkg::ST_SCMP: begin
				// narrow the lower-bound window
				if ($signed(rdata) < $signed(key_q)) begin
					lo_d = mid_q + CW'(1);
				end else begin
					hi_d = mid_q;
				end
				state_d = okset_pkg::ST_SRD;
			end
			okset_pkg::ST_PCHK: begin
				case (okset_pkg::op_t'(op_q))
					okset_pkg::OP_INSERT: begin
						if (hit) begin
							emit    = 1'b1;
							state_d = okset_pkg::ST_IDLE;
						end else if (count_q == CW'(okset_pkg::CAPACITY)) begin
							emit    = 1'b1;
							rej_d   = 1'b1;
							state_d = okset_pkg::ST_IDLE;
						end else if (count_q == lo_q) begin
							state_d = okset_pkg::ST_INS;
						end else begin
							idx_d   = count_q;
							state_d = okset_pkg::ST_SHRD;
						end
					end
					okset_pkg::OP_DELETE: begin
						if (!hit) begin
							emit    = 1'b1;
							state_d = okset_pkg::ST_IDLE;
						end else if (lo_q + CW'(1) < count_q) begin
							idx_d   = lo_q;
							state_d = okset_pkg::ST_SHRD;
						end else begin
							state_d = okset_pkg::ST_DEL;
						end
					end
					okset_pkg::OP_EXIST: begin
						emit    = 1'b1;
						found_d = hit;
						state_d = okset_pkg::ST_IDLE;
					end
					okset_pkg::OP_NEXT: begin
						if (nxt_idx < count_q) begin
							raddr   = nxt_idx[AW-1:0];
							state_d = okset_pkg::ST_FETCH;
						end else begin
							emit    = 1'b1;
							state_d = okset_pkg::ST_IDLE;
						end
					end
					okset_pkg::OP_PREV: begin
						if (lo_q != '0) begin
							raddr   = AW'(lo_q - CW'(1));
							state_d = okset_pkg::ST_FETCH;
						end else begin
							emit    = 1'b1;
							state_d = okset_pkg::ST_IDLE;
						end
					end
					default: begin
						emit    = 1'b1;
						state_d = okset_pkg::ST_IDLE;
					end
				endcase
			end
			okset_pkg::ST_SHRD: begin
				// fetch the neighbor that moves into idx
				if (op_q == 3'(okset_pkg::OP_INSERT)) begin
					raddr = AW'(idx_q - CW'(1));
				end else begin
					raddr = AW'(idx_q + CW'(1));
				end
				state_d = okset_pkg::ST_SHWR;
			end
			okset_pkg::ST_SHWR: begin
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = rdata;
				if (op_q == 3'(okset_pkg::OP_INSERT)) begin
					idx_d   = idx_q - CW'(1);
					state_d = (idx_q - CW'(1) == lo_q) ? okset_pkg::ST_INS
						: okset_pkg::ST_SHRD;
				end else begin
					idx_d   = idx_q + CW'(1);
					state_d = (idx_q + CW'(2) < count_q) ? okset_pkg::ST_SHRD
						: okset_pkg::ST_DEL;
				end
			end
			okset_pkg::ST_INS: begin
				we      = 1'b1;
				waddr   = lo_q[AW-1:0];
				wdata   = key_q;
				count_d = count_q + CW'(1);
				emit    = 1'b1;
				state_d = okset_pkg::ST_IDLE;
			end
			okset_pkg::ST_DEL: begin
				count_d = count_q - CW'(1);
				emit    = 1'b1;
				state_d = okset_pkg::ST_IDLE;
			end
			okset_pkg::ST_FETCH: begin
				emit    = 1'b1;
				found_d = 1'b1;
				res_d   = rdata;
				state_d = okset_pkg::ST_IDLE;
			end
			default: begin
				state_d = okset_pkg::ST_IDLE;
			end
		endcase
	end

	// occupancy never exceeds the store size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy <= 9'(okset_pkg::CAPACITY))
		else $error("occupancy above capacity");

	// a rejected insert reports a full store
	a_rej_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rejected |-> occupancy == 9'(okset_pkg::CAPACITY))
		else $error("reject without full store");

	// a nonzero result key only comes with found
	a_res_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_key != 0 |-> found)
		else $error("result key without found");

	// an accepted transaction either works on or answers at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction dropped");
endmodule
`default_nettype wire

// ===== sv/okset_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none
module okset_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
